[rtl/assert_macros.svh]
// Assertion macros used by the cache datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("assertion failed");
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define ASSERT_SAME(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/arpc_pkg.sv]
// Types and codes shared by the address cache controller and datapath.
package arpc_pkg;
  localparam logic [1:0] MODE_INS    = 2'd0;
  localparam logic [1:0] MODE_LKP    = 2'd1;
  localparam logic [1:0] MODE_REV    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PENDING  = 3'd1;
  localparam logic [2:0] ST_MISS     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_NOROOM   = 3'd4;

  localparam logic [3:0] OP_NONE        = 4'd0;
  localparam logic [3:0] OP_SCAN        = 4'd1;
  localparam logic [3:0] OP_COMPACT_EXP = 4'd2;
  localparam logic [3:0] OP_COMPACT_VIC = 4'd3;
  localparam logic [3:0] OP_SHIFT       = 4'd4;
  localparam logic [3:0] OP_WR_HIT_INS  = 4'd5;
  localparam logic [3:0] OP_WR_HIT_REF  = 4'd6;
  localparam logic [3:0] OP_WR_HEAD_INS = 4'd7;
  localparam logic [3:0] OP_WR_HEAD_MISS = 4'd8;

  localparam logic [31:0] EXPIRY_RESET = 32'd60000;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } arpc_entry_t;

  typedef struct packed {
    logic       req_load;
    logic [3:0] op;
    logic       res_load;
    logic [2:0] res_code;
    logic       res_query;
  } arpc_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
    logic hit_mac_zero;
    logic hit_stamp_zero;
    logic full;
    logic vic_found;
    logic new_exp;
    logic out_busy;
  } arpc_stat_t;
endpackage

[rtl/arpc_datapath.sv]
// Entry memory, sweep engine, request and result registers of the cache.
`include "assert_macros.svh"
module arpc_datapath import arpc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  arpc_cmd_t   cmd,
  output arpc_stat_t  stat,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic [1:0]  mode,
  input  logic [31:0] ip_addr,
  input  logic [47:0] hw_addr,
  input  logic [31:0] entry_time,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [47:0] mac_out,
  output logic [31:0] ip_out,
  output logic        send_query
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  arpc_entry_t mem [ENTRIES];
  arpc_entry_t mem_q;

  logic [1:0]  mode_r;
  logic [31:0] ip_r, etime_r, now_r, expiry;
  logic [47:0] mac_r;
  logic [CW-1:0] n, sw_left, len, wptr;
  logic [IW-1:0] sw_idx, ptag, hit_k, vic, first;
  logic [3:0]  sw_op;
  logic        sw_busy, pv, done;
  logic        found, vic_found;
  logic [31:0] best;
  arpc_entry_t hit_e;

  logic [31:0] age;
  logic        exp_e, kill, match, full, start;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  arpc_entry_t wr_data;

  assign full  = (n == CW'(ENTRIES));
  assign start = (cmd.op == OP_SCAN) || (cmd.op == OP_COMPACT_EXP) ||
                 (cmd.op == OP_COMPACT_VIC) || (cmd.op == OP_SHIFT);

  always_comb begin
    if (cmd.op == OP_SHIFT) begin
      len = full ? CW'(vic) : n;
    end else begin
      len = n;
    end
    first = (cmd.op == OP_SHIFT) ? IW'(len - CW'(1)) : '0;
  end

  assign age   = now_r - mem_q.stamp;
  assign exp_e = (mem_q.stamp != 32'd0) && (age >= expiry);
  assign kill  = (sw_op == OP_COMPACT_EXP) ? exp_e : (ptag == vic);
  assign match = (mode_r == MODE_REV) ? ((mem_q.mac != 48'd0) && (mem_q.mac == mac_r))
                                      : (mem_q.ip == ip_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = mem_q;
    unique case (cmd.op)
      OP_WR_HIT_INS: begin
        wr_en   = 1'b1;
        wr_addr = hit_k;
        wr_data = '{ip: ip_r, mac: mac_r, stamp: etime_r};
      end
      OP_WR_HIT_REF: begin
        wr_en   = 1'b1;
        wr_addr = hit_k;
        wr_data = '{ip: hit_e.ip, mac: hit_e.mac, stamp: now_r};
      end
      OP_WR_HEAD_INS: begin
        wr_en   = 1'b1;
        wr_data = '{ip: ip_r, mac: mac_r, stamp: etime_r};
      end
      OP_WR_HEAD_MISS: begin
        wr_en   = 1'b1;
        wr_data = '{ip: ip_r, mac: 48'd0, stamp: now_r};
      end
      default: begin
        if (sw_busy && pv) begin
          if (sw_op == OP_SHIFT) begin
            wr_en   = 1'b1;
            wr_addr = ptag + IW'(1);
          end else if (sw_op == OP_COMPACT_EXP || sw_op == OP_COMPACT_VIC) begin
            wr_en   = !kill;
            wr_addr = IW'(wptr);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[sw_idx];
  end

  // request registers and scan results
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      mode_r  <= mode;
      ip_r    <= ip_addr;
      mac_r   <= hw_addr;
      etime_r <= entry_time;
      now_r   <= now;
    end
    if (start) begin
      wptr <= '0;
    end else if (sw_busy && pv && !kill &&
                 (sw_op == OP_COMPACT_EXP || sw_op == OP_COMPACT_VIC)) begin
      wptr <= wptr + CW'(1);
    end
    if (sw_busy && pv && sw_op == OP_SCAN) begin
      if (!found && match) begin
        hit_k <= ptag;
        hit_e <= mem_q;
      end
      if (mem_q.stamp != 32'd0 && (!vic_found || age >= best)) begin
        best <= age;
        vic  <= ptag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_busy   <= 1'b0;
      pv        <= 1'b0;
      done      <= 1'b0;
      n         <= '0;
      found     <= 1'b0;
      vic_found <= 1'b0;
      out_valid <= 1'b0;
      expiry    <= EXPIRY_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        expiry <= cfg_wdata;
      end
      if (start) begin
        sw_busy <= 1'b1;
        sw_op   <= cmd.op;
        sw_left <= len;
        sw_idx  <= first;
        pv      <= 1'b0;
        if (cmd.op == OP_SCAN) begin
          found     <= 1'b0;
          vic_found <= 1'b0;
        end
      end else if (sw_busy) begin
        if (sw_left != '0) begin
          pv      <= 1'b1;
          ptag    <= sw_idx;
          sw_idx  <= (sw_op == OP_SHIFT) ? sw_idx - IW'(1) : sw_idx + IW'(1);
          sw_left <= sw_left - CW'(1);
        end else begin
          pv <= 1'b0;
        end
        if (pv && sw_op == OP_SCAN) begin
          if (match) begin
            found <= 1'b1;
          end
          if (mem_q.stamp != 32'd0) begin
            vic_found <= 1'b1;
          end
        end
        if (sw_left == '0 && !pv) begin
          sw_busy <= 1'b0;
          done    <= 1'b1;
          if (sw_op == OP_COMPACT_EXP || sw_op == OP_COMPACT_VIC) begin
            n <= wptr;
          end
        end
      end
      if ((cmd.op == OP_WR_HEAD_INS || cmd.op == OP_WR_HEAD_MISS) && !full) begin
        n <= n + CW'(1);
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status     <= cmd.res_code;
      send_query <= cmd.res_query;
      mac_out    <= (cmd.res_code == ST_OK && mode_r == MODE_LKP) ? hit_e.mac : 48'd0;
      ip_out     <= (cmd.res_code == ST_OK && mode_r == MODE_REV) ? hit_e.ip : 32'd0;
    end
  end

  assign stat.done           = done;
  assign stat.found          = found;
  assign stat.hit_mac_zero   = (hit_e.mac == 48'd0);
  assign stat.hit_stamp_zero = (hit_e.stamp == 32'd0);
  assign stat.full           = full;
  assign stat.vic_found      = vic_found;
  assign stat.new_exp        = (etime_r != 32'd0) && ((now_r - etime_r) >= expiry);
  assign stat.out_busy       = out_valid && out_stall;

  `ASSERT_ALWAYS(a_count_range, clk, rst, n <= CW'(ENTRIES))
  `ASSERT_NEXT(a_head_grows, clk, rst, (cmd.op == OP_WR_HEAD_MISS) && !full, n == $past(n) + CW'(1))
  `ASSERT_SAME(a_done_after_sweep, clk, rst, done, $past(sw_busy))
endmodule

[rtl/arpc_ctrl.sv]
// Request sequencer of the address cache.
module arpc_ctrl import arpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  arpc_stat_t stat,
  output arpc_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISP      = 4'd1;
  localparam logic [3:0] S_INS_FIND  = 4'd2;
  localparam logic [3:0] S_INS_EXP   = 4'd3;
  localparam logic [3:0] S_INS_VIC   = 4'd4;
  localparam logic [3:0] S_INS_SHIFT = 4'd5;
  localparam logic [3:0] S_LKP_EXP   = 4'd6;
  localparam logic [3:0] S_LKP_FIND  = 4'd7;
  localparam logic [3:0] S_LKP_SHIFT = 4'd8;
  localparam logic [3:0] S_REV       = 4'd9;
  localparam logic [3:0] S_DROP      = 4'd10;
  localparam logic [3:0] S_RESP      = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] mode_r;
  logic [2:0] code, code_next;
  logic       query, query_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    code_next  = code;
    query_next = query;
    cmd        = '0;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        query_next = 1'b0;
        unique case (mode_r)
          MODE_INS: begin
            cmd.op = OP_SCAN;
            state_next = S_INS_FIND;
          end
          MODE_LKP: begin
            cmd.op = OP_COMPACT_EXP;
            state_next = S_LKP_EXP;
          end
          MODE_REV: begin
            cmd.op = OP_SCAN;
            state_next = S_REV;
          end
          default: begin
            code_next  = ST_NOTFOUND;
            state_next = S_RESP;
          end
        endcase
      end
      S_INS_FIND: begin
        if (stat.done) begin
          if (stat.found) begin
            cmd.op     = OP_WR_HIT_INS;
            code_next  = ST_OK;
            state_next = S_RESP;
          end else begin
            cmd.op     = OP_COMPACT_EXP;
            state_next = S_INS_EXP;
          end
        end
      end
      S_INS_EXP: begin
        if (stat.done) begin
          cmd.op     = OP_SCAN;
          state_next = S_INS_VIC;
        end
      end
      S_INS_VIC: begin
        if (stat.done) begin
          code_next = ST_OK;
          priority if (stat.full && !stat.vic_found) begin
            code_next  = ST_NOROOM;
            state_next = S_RESP;
          end else if (stat.new_exp) begin
            // an entry that is stale on arrival is not inserted; when full, its victim's slot is still freed
            if (stat.full) begin
              cmd.op     = OP_COMPACT_VIC;
              state_next = S_DROP;
            end else begin
              state_next = S_RESP;
            end
          end else begin
            cmd.op     = OP_SHIFT;
            state_next = S_INS_SHIFT;
          end
        end
      end
      S_INS_SHIFT: begin
        if (stat.done) begin
          cmd.op     = OP_WR_HEAD_INS;
          state_next = S_RESP;
        end
      end
      S_LKP_EXP: begin
        if (stat.done) begin
          cmd.op     = OP_SCAN;
          state_next = S_LKP_FIND;
        end
      end
      S_LKP_FIND: begin
        if (stat.done) begin
          priority if (stat.found && stat.hit_mac_zero) begin
            code_next  = ST_PENDING;
            state_next = S_RESP;
          end else if (stat.found) begin
            if (!stat.hit_stamp_zero) begin
              cmd.op = OP_WR_HIT_REF;
            end
            code_next  = ST_OK;
            state_next = S_RESP;
          end else if (stat.full && !stat.vic_found) begin
            code_next  = ST_NOROOM;
            state_next = S_RESP;
          end else begin
            cmd.op     = OP_SHIFT;
            state_next = S_LKP_SHIFT;
          end
        end
      end
      S_LKP_SHIFT: begin
        if (stat.done) begin
          cmd.op     = OP_WR_HEAD_MISS;
          code_next  = ST_MISS;
          query_next = 1'b1;
          state_next = S_RESP;
        end
      end
      S_REV: begin
        if (stat.done) begin
          if (stat.found) begin
            if (!stat.hit_stamp_zero) begin
              cmd.op = OP_WR_HIT_REF;
            end
            code_next = ST_OK;
          end else begin
            code_next = ST_NOTFOUND;
          end
          state_next = S_RESP;
        end
      end
      S_DROP: begin
        if (stat.done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.res_load  = 1'b1;
          cmd.res_code  = code;
          cmd.res_query = query;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (cmd.req_load) begin
      mode_r <= mode;
    end
    code  <= code_next;
    query <= query_next;
  end
endmodule

[rtl/arp_cache_table_unit.sv]
// Top level of the IPv4 to MAC address cache with aging.
// Each request runs as sweeps over the entry memory, one entry a cycle through its
//   single read port; reverse lookups and insert hits need only the find sweep, while
//   lookups and insert misses add expire-compact and shift sweeps as needed.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: rst (synchronous) empties the table via its fill count and restores expiry.
module arp_cache_table_unit import arpc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] ip_addr,
  input  logic [47:0] hw_addr,
  input  logic [31:0] entry_time,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [47:0] mac_out,
  output logic [31:0] ip_out,
  output logic        send_query
);
  arpc_cmd_t  cmd;
  arpc_stat_t stat;

  // sequence each request as sweeps: find, expire-compact, victim scan, shift
  arpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold the table, the request and the result register
  arpc_datapath #(.ENTRIES(ENTRIES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mode       (mode),
    .ip_addr    (ip_addr),
    .hw_addr    (hw_addr),
    .entry_time (entry_time),
    .now        (now),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .mac_out    (mac_out),
    .ip_out     (ip_out),
    .send_query (send_query)
  );
endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the IPv4-to-MAC address cache with aging.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arpc_pkg::*;

  localparam int SLOTS      = 16;
  localparam int POOL       = 24;     // more addresses than slots, so the table fills
  localparam int DRAIN      = 80;     // idle cycles after the queues drain, to let the last request finish
  localparam int STALL_MAX  = 20000;  // cycles with no handshake before giving up
  localparam int PER_PHASE  = 390;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] etime;
    logic [31:0] now;
  } arp_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] mac;
    logic [31:0] ip;
    logic        query;
  } arp_resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = '0;
  logic [31:0] ip_addr = '0;
  logic [47:0] hw_addr = '0;
  logic [31:0] entry_time = '0;
  logic [31:0] now = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [47:0] mac_out;
  logic [31:0] ip_out;
  logic        send_query;

  arp_cache_table_unit #(.ENTRIES(SLOTS)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .ip_addr(ip_addr), .hw_addr(hw_addr),
    .entry_time(entry_time), .now(now),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .mac_out(mac_out), .ip_out(ip_out), .send_query(send_query)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow table: an ordered list, head at slot 0, live entries in 0..cnt-1.
  // ---------------------------------------------------------------------
  logic [31:0] tbl_ip[SLOTS];
  logic [47:0] tbl_mac[SLOTS];
  logic [31:0] tbl_stamp[SLOTS];
  int          tbl_cnt = 0;
  logic [31:0] expiry = EXPIRY_RESET;

  arp_req_t  pending_q[$];   // requests waiting for the driver
  arp_resp_t answer_q[$];    // predicted answers, oldest first

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          mismatches = 0;
  bit          failed = 1'b0;
  int          quiet_cycles = 0;
  logic [31:0] tick;

  // Remove slot k and close the gap toward the head.
  function automatic void drop_slot(int k);
    for (int i = k; i + 1 < tbl_cnt; i++) begin
      tbl_ip[i] = tbl_ip[i + 1];
      tbl_mac[i] = tbl_mac[i + 1];
      tbl_stamp[i] = tbl_stamp[i + 1];
    end
    tbl_cnt--;
  endfunction

  // Timed entries age with wrapping 32-bit subtraction.
  function automatic bit aged_out(int k, logic [31:0] t);
    logic [31:0] age;
    age = t - tbl_stamp[k];
    return tbl_stamp[k] != 0 && age >= expiry;
  endfunction

  function automatic void sweep_aged(logic [31:0] t);
    int i;
    i = 0;
    while (i < tbl_cnt) begin
      if (aged_out(i, t)) drop_slot(i);
      else i++;
    end
  endfunction

  // Add at the head; when full, evict the oldest timed entry (tail wins ties).
  function automatic bit add_head(logic [31:0] a, logic [47:0] m, logic [31:0] s,
                                  logic [31:0] t);
    bit          found;
    int          victim;
    logic [31:0] best;
    logic [31:0] age;
    if (tbl_cnt >= SLOTS) begin
      found = 1'b0;
      victim = 0;
      best = '0;
      for (int i = 0; i < tbl_cnt; i++) begin
        if (tbl_stamp[i] != 0) begin
          age = t - tbl_stamp[i];
          if (!found || age >= best) begin
            found = 1'b1;
            best = age;
            victim = i;
          end
        end
      end
      if (!found) return 1'b0;
      drop_slot(victim);
    end
    for (int i = tbl_cnt; i > 0; i--) begin
      tbl_ip[i] = tbl_ip[i - 1];
      tbl_mac[i] = tbl_mac[i - 1];
      tbl_stamp[i] = tbl_stamp[i - 1];
    end
    tbl_ip[0] = a;
    tbl_mac[0] = m;
    tbl_stamp[0] = s;
    tbl_cnt++;
    return 1'b1;
  endfunction

  function automatic int find_addr(logic [31:0] a);
    for (int i = 0; i < tbl_cnt; i++)
      if (tbl_ip[i] == a) return i;
    return -1;
  endfunction

  // Apply one request to the shadow table and return the expected answer.
  function automatic arp_resp_t resolve(arp_req_t r);
    arp_resp_t o;
    int        k;
    o.status = ST_NOTFOUND;
    o.mac = '0;
    o.ip = '0;
    o.query = 1'b0;
    case (r.mode)
      MODE_INS: begin
        k = find_addr(r.ip);
        if (k >= 0) begin
          // update in place, no aging sweep
          tbl_mac[k] = r.mac;
          tbl_stamp[k] = r.etime;
          o.status = ST_OK;
        end else begin
          sweep_aged(r.now);
          if (!add_head(r.ip, r.mac, r.etime, r.now)) begin
            o.status = ST_NOROOM;
          end else begin
            if (aged_out(0, r.now)) drop_slot(0);
            o.status = ST_OK;
          end
        end
      end
      MODE_LKP: begin
        sweep_aged(r.now);
        k = find_addr(r.ip);
        if (k >= 0) begin
          if (tbl_mac[k] == 0) begin
            o.status = ST_PENDING;
          end else begin
            o.mac = tbl_mac[k];
            if (tbl_stamp[k] != 0) tbl_stamp[k] = r.now;
            o.status = ST_OK;
          end
        end else if (add_head(r.ip, '0, r.now, r.now)) begin
          o.status = ST_MISS;
          o.query = 1'b1;
        end else begin
          o.status = ST_NOROOM;
        end
      end
      MODE_REV: begin
        for (int i = 0; i < tbl_cnt; i++) begin
          if (tbl_mac[i] != 0 && tbl_mac[i] == r.mac) begin
            o.ip = tbl_ip[i];
            if (tbl_stamp[i] != 0) tbl_stamp[i] = r.now;
            o.status = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: hold a stalled request, otherwise advance to the next one or idle.
  // Predict at the edge where the request is taken.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    arp_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        r.mode = mode;
        r.ip = ip_addr;
        r.mac = hw_addr;
        r.etime = entry_time;
        r.now = now;
        answer_q.push_back(resolve(r));
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          r = pending_q.pop_front();
          mode <= r.mode;
          ip_addr <= r.ip;
          hw_addr <= r.mac;
          entry_time <= r.etime;
          now <= r.now;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each taken answer with the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    arp_resp_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: answer with no request outstanding: status %0d", $realtime, status);
        end else begin
          want = answer_q.pop_front();
          if (status !== want.status || mac_out !== want.mac || ip_out !== want.ip ||
              send_query !== want.query) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected status %0d mac %h ip %h query %0d, got %0d %h %h %0d",
                       $realtime, want.status, want.mac, want.ip, want.query,
                       status, mac_out, ip_out, send_query);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: end the run if no handshake happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic [31:0] pool_ip(int i);
    return 32'h0A00_0000 + i;
  endfunction

  function automatic logic [47:0] pool_mac(int i);
    return 48'h0200_0000_0100 + i;
  endfunction

  function automatic logic [47:0] any_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic arp_req_t mk(logic [1:0] md, logic [31:0] a, logic [47:0] m,
                                  logic [31:0] et, logic [31:0] t);
    arp_req_t r;
    r.mode = md;
    r.ip = a;
    r.mac = m;
    r.etime = et;
    r.now = t;
    return r;
  endfunction

  // Random request: mostly pool addresses so hits, refreshes and evictions occur.
  function automatic arp_req_t rand_req();
    arp_req_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.mode = pick < 40 ? MODE_INS : pick < 80 ? MODE_LKP : pick < 97 ? MODE_REV : MODE_UNUSED;
    r.ip = $urandom_range(0, 99) < 85 ? pool_ip($urandom_range(0, POOL - 1)) : $urandom;
    pick = $urandom_range(0, 99);
    r.mac = pick < 10 ? 48'd0 : pick < 70 ? pool_mac($urandom_range(0, POOL - 1)) : any_mac();
    pick = $urandom_range(0, 99);
    // advance the clock of ticks; sometimes jump far or wrap to zero
    if (pick < 3) tick = 0;
    else if (pick < 8) tick = $urandom;
    else tick = tick + $urandom_range(0, 400);
    r.now = tick;
    pick = $urandom_range(0, 99);
    r.etime = pick < 20 ? 32'd0 : pick < 70 ? tick :
              pick < 90 ? tick - $urandom_range(0, 1000) : $urandom;
    return r;
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || answer_q.size() != 0 || in_valid)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_expiry(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    expiry = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [31:0] phase_expiry[5];
    int unsigned phase_idle[5];
    int unsigned phase_stall[5];
    phase_expiry = '{EXPIRY_RESET, 32'd1, 32'd600, 32'hFFFF_FFFF, 32'd600};
    phase_idle   = '{0, 48, 0, 9, 0};
    phase_stall  = '{0, 0, 48, 9, 0};
    tick = 32'd1000;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: miss, pending, update, hit, reverse hit, odd cases, full table.
    pending_q.push_back(mk(MODE_LKP, pool_ip(20), '0, '0, 32'd1000));
    pending_q.push_back(mk(MODE_LKP, pool_ip(20), '0, '0, 32'd1001));
    pending_q.push_back(mk(MODE_REV, '0, 48'd0, '0, 32'd1002));
    pending_q.push_back(mk(MODE_INS, pool_ip(20), pool_mac(20), 32'd1002, 32'd1002));
    pending_q.push_back(mk(MODE_LKP, pool_ip(20), '0, '0, 32'd1003));
    pending_q.push_back(mk(MODE_REV, '0, pool_mac(20), '0, 32'd1004));
    pending_q.push_back(mk(MODE_REV, '1, 48'hFFFF_FFFF_FFFF, '1, '1));
    pending_q.push_back(mk(MODE_UNUSED, '1, '1, '1, '1));
    // stamp ahead of now wraps to a huge age and is removed at once
    pending_q.push_back(mk(MODE_INS, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd1100, 32'd1005));
    pending_q.push_back(mk(MODE_LKP, 32'hFFFF_FFFF, '0, '0, 32'd1006));
    // zero now on a lookup miss yields a permanent incomplete entry
    pending_q.push_back(mk(MODE_LKP, 32'd0, '0, '0, 32'd0));
    // fill with permanent entries, then ask for room that does not exist
    for (int i = 0; i < SLOTS - 2; i++)
      pending_q.push_back(mk(MODE_INS, pool_ip(i), pool_mac(i), 32'd0, 32'd1010));
    pending_q.push_back(mk(MODE_INS, pool_ip(21), pool_mac(21), 32'd0, 32'd1010));
    pending_q.push_back(mk(MODE_LKP, pool_ip(22), '0, '0, 32'd1011));
    pending_q.push_back(mk(MODE_INS, pool_ip(22), pool_mac(22), 32'd1011, 32'd1011));

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        wait_idle();
        write_expiry(phase_expiry[p]);
      end
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int n = 0; n < PER_PHASE; n++)
        pending_q.push_back(rand_req());
    end

    wait_idle();
    if (answer_q.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
